// ----- design/imu_sfp_pkg.sv -----
// ----------------------------------------------------------------------------
// imu_sfp_pkg: shared types and constants for the IMU serial frame parser
// Frame delimiters, type codes, frame lengths, status codes and the result
// record that the parser hands out.
// ----------------------------------------------------------------------------
package imu_sfp_pkg;

   // frame delimiters
   localparam logic [7:0] HDR_FIRST  = 8'h55;
   localparam logic [7:0] HDR_SECOND = 8'hAA;
   localparam logic [7:0] FRAME_END  = 8'h0A;

   // frame types
   localparam logic [7:0] KIND_FIRST = 8'h01;
   localparam logic [7:0] KIND_GYRO  = 8'h02;
   localparam logic [7:0] KIND_YAW   = 8'h03;
   localparam logic [7:0] KIND_QUAT  = 8'h04;

   // byte positions and lengths
   localparam int unsigned POS_W = 5;
   localparam logic [POS_W-1:0] LEN_STD    = 5'd19;
   localparam logic [POS_W-1:0] LEN_QUAT   = 5'd23;
   localparam logic [POS_W-1:0] VAL_OFFSET = 5'd12;
   localparam logic [POS_W-1:0] VAL_LAST   = 5'd15;
   localparam logic [POS_W-1:0] POS_LIMIT  = 5'd24;
   localparam logic [POS_W-1:0] POS_HUNT   = 5'd0;
   localparam logic [POS_W-1:0] POS_HDR2   = 5'd1;
   localparam logic [POS_W-1:0] POS_ID     = 5'd2;
   localparam logic [POS_W-1:0] POS_KIND   = 5'd3;
   localparam logic [POS_W-1:0] POS_BODY   = 5'd4;

   // float bit patterns
   localparam int unsigned LIMIT_W = 31;
   localparam logic [LIMIT_W-1:0] INF_BITS        = 31'h7F800000;
   localparam logic [LIMIT_W-1:0] GYRO_LIMIT_RST  = 31'h44FA0000;
   localparam logic [LIMIT_W-1:0] YAW_LIMIT_RST   = 31'h43B40000;

   // configuration register indexes
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_YAW_LIMIT  = 2'd1;

   // frame status codes
   localparam logic [2:0] ST_GYRO_OK  = 3'd0;
   localparam logic [2:0] ST_YAW_OK   = 3'd1;
   localparam logic [2:0] ST_OTHER_OK = 3'd2;
   localparam logic [2:0] ST_BAD_END  = 3'd3;
   localparam logic [2:0] ST_NAN      = 3'd4;
   localparam logic [2:0] ST_RANGE    = 3'd5;
   localparam logic [2:0] ST_BAD_TYPE = 3'd6;

   // one result record
   typedef struct packed {
      logic [2:0]  frame_status;
      logic [31:0] gyro_value_bits;
      logic [31:0] gyro_count;
      logic        gyro_ok;
      logic [31:0] yaw_value_bits;
      logic [31:0] yaw_count;
      logic        yaw_ok;
      logic [31:0] good_frames;
      logic [31:0] bad_frames;
   } rsp_item_type;

endpackage

// ----- design/imu_sfp_if.sv -----
// ----------------------------------------------------------------------------
// imu_sfp_if: channel interfaces of the IMU serial frame parser
// Byte input channel, result channel and configuration write channel, each
// with valid/ready and a source and a sink modport.
// ----------------------------------------------------------------------------
interface imu_sfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface imu_sfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  frame_status;
   logic [31:0] gyro_value_bits;
   logic [31:0] gyro_count;
   logic        gyro_ok;
   logic [31:0] yaw_value_bits;
   logic [31:0] yaw_count;
   logic        yaw_ok;
   logic [31:0] good_frames;
   logic [31:0] bad_frames;

   modport source (output valid, output frame_status, output gyro_value_bits,
                   output gyro_count, output gyro_ok, output yaw_value_bits,
                   output yaw_count, output yaw_ok, output good_frames,
                   output bad_frames, input ready);
   modport sink   (input valid, input frame_status, input gyro_value_bits,
                   input gyro_count, input gyro_ok, input yaw_value_bits,
                   input yaw_count, input yaw_ok, input good_frames,
                   input bad_frames, output ready);
endinterface

interface imu_sfp_csr_if;
   logic                               valid;
   logic                               ready;
   logic [imu_sfp_pkg::CSR_IDX_W-1:0]  index;
   logic [31:0]                        data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/imu_serial_frame_parser.sv -----
// ----------------------------------------------------------------------------
// imu_serial_frame_parser: byte-serial IMU frame parser
// Hunts for the 0x55 0xAA header, checks type, length and terminator, and
// keeps the last good gyro and yaw values with their counts.
// ----------------------------------------------------------------------------
// The parser takes one received byte per clock cycle. Each byte is decoded
// against the frame state combinationally; when a byte ends or rejects a
// frame, a result transaction is written into a two-entry output buffer and
// is offered on rsp after any earlier ones. req is held off only while both
// buffer entries wait to be taken, so a stalled result never stops the byte
// stream for the first byte behind it. Configuration writes are taken in
// every cycle; writes to indexes beyond the two limit registers are ignored.
module imu_serial_frame_parser (
   input  logic                 clock,
   input  logic                 reset,
   imu_sfp_req_if.sink          req,
   imu_sfp_rsp_if.source        rsp,
   imu_sfp_csr_if.sink          csr
);

   // configuration registers
   logic [imu_sfp_pkg::LIMIT_W-1:0] gyro_limit_ff;
   logic [imu_sfp_pkg::LIMIT_W-1:0] yaw_limit_ff;

   // frame state
   logic [imu_sfp_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [imu_sfp_pkg::POS_W-1:0] len_ff, len_in;
   logic [7:0]                    kind_ff, kind_in;
   logic [31:0]                   shift_ff, shift_in;

   // kept values and counters
   logic [31:0] gyro_store_ff, gyro_store_in;
   logic [31:0] gyro_seq_ff, gyro_seq_in;
   logic        gyro_flag_ff, gyro_flag_in;
   logic [31:0] yaw_store_ff, yaw_store_in;
   logic [31:0] yaw_seq_ff, yaw_seq_in;
   logic        yaw_flag_ff, yaw_flag_in;
   logic [31:0] good_ff, good_in;
   logic [31:0] bad_ff, bad_in;

   // decode results
   logic       emit;
   logic [2:0] status;
   logic       accept;
   logic       pop;
   imu_sfp_pkg::rsp_item_type item;

   // output buffer
   imu_sfp_pkg::rsp_item_type slot0_ff, slot0_in;
   imu_sfp_pkg::rsp_item_type slot1_ff, slot1_in;
   logic                      v0_ff, v0_in;
   logic                      v1_ff, v1_in;

   assign req.ready = !v1_ff;
   assign accept    = req.valid && req.ready;
   assign pop       = rsp.valid && rsp.ready;
   assign csr.ready = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gyro_limit_ff <= imu_sfp_pkg::GYRO_LIMIT_RST;
         yaw_limit_ff  <= imu_sfp_pkg::YAW_LIMIT_RST;
      end else if (csr.valid && csr.ready) begin
         unique case (csr.index)
            imu_sfp_pkg::CSR_GYRO_LIMIT: gyro_limit_ff <= csr.data[30:0];
            imu_sfp_pkg::CSR_YAW_LIMIT:  yaw_limit_ff  <= csr.data[30:0];
            default: ;
         endcase
      end
   end

   // byte decode: next frame state, value updates and result status
   always_comb begin
      logic [7:0]                    b;
      logic [imu_sfp_pkg::POS_W-1:0] pos_nx;
      logic [imu_sfp_pkg::POS_W-1:0] restart_pos;
      logic [30:0]                   mag;
      logic                          finish;

      b           = req.rx_byte;
      restart_pos = (b == imu_sfp_pkg::HDR_FIRST) ? imu_sfp_pkg::POS_HDR2
                                                  : imu_sfp_pkg::POS_HUNT;
      pos_nx      = 5'(pos_ff + 5'd1);
      mag         = shift_ff[30:0];
      finish      = 1'b0;

      pos_in        = pos_ff;
      len_in        = len_ff;
      kind_in       = kind_ff;
      shift_in      = shift_ff;
      gyro_store_in = gyro_store_ff;
      gyro_seq_in   = gyro_seq_ff;
      gyro_flag_in  = gyro_flag_ff;
      yaw_store_in  = yaw_store_ff;
      yaw_seq_in    = yaw_seq_ff;
      yaw_flag_in   = yaw_flag_ff;
      emit          = 1'b0;
      status        = imu_sfp_pkg::ST_BAD_END;

      if (pos_ff == imu_sfp_pkg::POS_HUNT) begin
         if (b == imu_sfp_pkg::HDR_FIRST) pos_in = imu_sfp_pkg::POS_HDR2;
      end else if (pos_ff == imu_sfp_pkg::POS_HDR2) begin
         if (b == imu_sfp_pkg::HDR_SECOND) begin
            pos_in = imu_sfp_pkg::POS_ID;
         end else begin
            pos_in = restart_pos;
            len_in = '0;
         end
      end else if (pos_ff >= imu_sfp_pkg::POS_LIMIT) begin
         // corrupt position: treat as bad end
         pos_in = restart_pos;
         len_in = '0;
         emit   = 1'b1;
      end else if (pos_ff == imu_sfp_pkg::POS_ID) begin
         pos_in = imu_sfp_pkg::POS_KIND;
      end else if (pos_ff == imu_sfp_pkg::POS_KIND) begin
         if (b >= imu_sfp_pkg::KIND_FIRST && b <= imu_sfp_pkg::KIND_YAW) begin
            len_in  = imu_sfp_pkg::LEN_STD;
            kind_in = b;
            pos_in  = imu_sfp_pkg::POS_BODY;
         end else if (b == imu_sfp_pkg::KIND_QUAT) begin
            len_in  = imu_sfp_pkg::LEN_QUAT;
            kind_in = b;
            pos_in  = imu_sfp_pkg::POS_BODY;
         end else begin
            pos_in = restart_pos;
            len_in = '0;
            emit   = 1'b1;
            status = imu_sfp_pkg::ST_BAD_TYPE;
         end
      end else if (len_ff <= pos_ff) begin
         // length inconsistent with position
         pos_in = restart_pos;
         len_in = '0;
         emit   = 1'b1;
      end else begin
         if (pos_ff >= imu_sfp_pkg::VAL_OFFSET && pos_ff <= imu_sfp_pkg::VAL_LAST) begin
            shift_in = {b, shift_ff[31:8]};
         end
         pos_in = pos_nx;
         finish = (pos_nx == len_ff);
      end

      // last byte of the frame
      if (finish) begin
         pos_in = restart_pos;
         len_in = '0;
         emit   = 1'b1;
         if (b != imu_sfp_pkg::FRAME_END) begin
            status = imu_sfp_pkg::ST_BAD_END;
         end else if (kind_ff != imu_sfp_pkg::KIND_GYRO &&
                      kind_ff != imu_sfp_pkg::KIND_YAW) begin
            status = imu_sfp_pkg::ST_OTHER_OK;
         end else if (mag >= imu_sfp_pkg::INF_BITS) begin
            status = imu_sfp_pkg::ST_NAN;
         end else if (kind_ff == imu_sfp_pkg::KIND_GYRO) begin
            if (mag > gyro_limit_ff) begin
               status = imu_sfp_pkg::ST_RANGE;
            end else begin
               status        = imu_sfp_pkg::ST_GYRO_OK;
               gyro_store_in = shift_ff;
               gyro_seq_in   = gyro_seq_ff + 32'd1;
               gyro_flag_in  = 1'b1;
            end
         end else begin
            if (mag > yaw_limit_ff) begin
               status = imu_sfp_pkg::ST_RANGE;
            end else begin
               status       = imu_sfp_pkg::ST_YAW_OK;
               yaw_store_in = shift_ff;
               yaw_seq_in   = yaw_seq_ff + 32'd1;
               yaw_flag_in  = 1'b1;
            end
         end
      end

      // frame counters
      good_in = good_ff;
      bad_in  = bad_ff;
      if (emit) begin
         if (status <= imu_sfp_pkg::ST_OTHER_OK) good_in = good_ff + 32'd1;
         else                                    bad_in  = bad_ff + 32'd1;
      end

      item.frame_status    = status;
      item.gyro_value_bits = gyro_store_in;
      item.gyro_count      = gyro_seq_in;
      item.gyro_ok         = gyro_flag_in;
      item.yaw_value_bits  = yaw_store_in;
      item.yaw_count       = yaw_seq_in;
      item.yaw_ok          = yaw_flag_in;
      item.good_frames     = good_in;
      item.bad_frames      = bad_in;
   end

   // frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         len_ff        <= '0;
         kind_ff       <= '0;
         shift_ff      <= '0;
         gyro_store_ff <= '0;
         gyro_seq_ff   <= '0;
         gyro_flag_ff  <= 1'b0;
         yaw_store_ff  <= '0;
         yaw_seq_ff    <= '0;
         yaw_flag_ff   <= 1'b0;
         good_ff       <= '0;
         bad_ff        <= '0;
      end else if (accept) begin
         pos_ff        <= pos_in;
         len_ff        <= len_in;
         kind_ff       <= kind_in;
         shift_ff      <= shift_in;
         gyro_store_ff <= gyro_store_in;
         gyro_seq_ff   <= gyro_seq_in;
         gyro_flag_ff  <= gyro_flag_in;
         yaw_store_ff  <= yaw_store_in;
         yaw_seq_ff    <= yaw_seq_in;
         yaw_flag_ff   <= yaw_flag_in;
         good_ff       <= good_in;
         bad_ff        <= bad_in;
      end
   end

   // two-entry output buffer: pop shifts slot1 forward, push fills first free
   always_comb begin
      logic a0;
      logic a1;

      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      a0       = v0_ff;
      a1       = v1_ff;
      if (pop) begin
         slot0_in = slot1_ff;
         a0       = v1_ff;
         a1       = 1'b0;
      end
      if (accept && emit) begin
         if (!a0) begin
            slot0_in = item;
            a0       = 1'b1;
         end else begin
            slot1_in = item;
            a1       = 1'b1;
         end
      end
      v0_in = a0;
      v1_in = a1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   // result channel
   assign rsp.valid           = v0_ff;
   assign rsp.frame_status    = slot0_ff.frame_status;
   assign rsp.gyro_value_bits = slot0_ff.gyro_value_bits;
   assign rsp.gyro_count      = slot0_ff.gyro_count;
   assign rsp.gyro_ok         = slot0_ff.gyro_ok;
   assign rsp.yaw_value_bits  = slot0_ff.yaw_value_bits;
   assign rsp.yaw_count       = slot0_ff.yaw_count;
   assign rsp.yaw_ok          = slot0_ff.yaw_ok;
   assign rsp.good_frames     = slot0_ff.good_frames;
   assign rsp.bad_frames      = slot0_ff.bad_frames;

   // checks
   a_buf_order: assert property (@(posedge clock) disable iff (reset)
      v1_ff |-> v0_ff)
      else $error("second buffer entry held without first");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff < imu_sfp_pkg::POS_LIMIT)
      else $error("byte position out of range");

   a_len_cover: assert property (@(posedge clock) disable iff (reset)
      (pos_ff >= imu_sfp_pkg::POS_BODY) |-> (len_ff > pos_ff))
      else $error("frame length not above byte position");

   a_flag_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(gyro_flag_ff) && !$fell(yaw_flag_ff))
      else $error("value valid flag dropped");

endmodule

// ----- tb/sv/imu_serial_frame_parser_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_serial_frame_parser_checker: result checker for the IMU frame parser
// Watches the byte, result and register channels, keeps its own copy of the
// parser state and limits, works out the result that each accepted byte
// causes and compares every result transaction field by field, in order.
// ----------------------------------------------------------------------------
module imu_serial_frame_parser_checker
   import imu_sfp_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   imu_sfp_req_if req,
   imu_sfp_rsp_if rsp,
   imu_sfp_csr_if csr,
   output int     errors,
   output int     pending,
   output int     checked
);

   // limits and parser state as the block should hold them
   logic [LIMIT_W-1:0] gyro_limit;
   logic [LIMIT_W-1:0] yaw_limit;
   logic [POS_W-1:0]   position;
   logic [POS_W-1:0]   frame_len;
   logic [7:0]         kind;
   logic [31:0]        value_sr;
   logic [31:0]        gyro_bits;
   logic [31:0]        gyro_seq_cnt;
   logic               gyro_seen;
   logic [31:0]        yaw_bits;
   logic [31:0]        yaw_seq_cnt;
   logic               yaw_seen;
   logic [31:0]        good_cnt;
   logic [31:0]        bad_cnt;

   rsp_item_type expected_q[$];
   int           mismatches = 0;
   int           compared = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch(what, got, want);
      end
   endtask

   // back to hunting; a 0x55 counts as a fresh first header byte
   task automatic rehunt(input logic [7:0] b);
      frame_len = '0;
      position  = (b == HDR_FIRST) ? POS_HDR2 : POS_HUNT;
   endtask

   // count the frame and queue the transaction that should come out
   task automatic log_result(input logic [2:0] st);
      rsp_item_type item;
      if (st <= ST_OTHER_OK) begin
         good_cnt = good_cnt + 1'b1;
      end else begin
         bad_cnt = bad_cnt + 1'b1;
      end
      item.frame_status    = st;
      item.gyro_value_bits = gyro_bits;
      item.gyro_count      = gyro_seq_cnt;
      item.gyro_ok         = gyro_seen;
      item.yaw_value_bits  = yaw_bits;
      item.yaw_count       = yaw_seq_cnt;
      item.yaw_ok          = yaw_seen;
      item.good_frames     = good_cnt;
      item.bad_frames      = bad_cnt;
      expected_q.push_back(item);
   endtask

   // one received byte through the frame state
   task automatic consume_byte(input logic [7:0] b);
      logic [2:0] st;
      if (position == POS_HUNT) begin
         if (b == HDR_FIRST) position = POS_HDR2;
         return;
      end
      if (position == POS_HDR2) begin
         if (b == HDR_SECOND) begin
            position = POS_ID;
         end else begin
            rehunt(b);
         end
         return;
      end
      if (position >= POS_LIMIT) begin
         rehunt(b);
         log_result(ST_BAD_END);
         return;
      end
      if (position == POS_ID) begin
         position = POS_KIND;
         return;
      end
      if (position == POS_KIND) begin
         if (b >= KIND_FIRST && b <= KIND_YAW) begin
            frame_len = LEN_STD;
         end else if (b == KIND_QUAT) begin
            frame_len = LEN_QUAT;
         end else begin
            rehunt(b);
            log_result(ST_BAD_TYPE);
            return;
         end
         kind     = b;
         position = POS_BODY;
         return;
      end
      if (frame_len <= position) begin
         rehunt(b);
         log_result(ST_BAD_END);
         return;
      end
      // value bytes arrive little-endian, shifted in from the top
      if (position >= VAL_OFFSET && position <= VAL_LAST) begin
         value_sr = {b, value_sr[31:8]};
      end
      position = position + 1'b1;
      if (position != frame_len) return;

      // last byte: terminator, then the value checks on the bit pattern
      if (b != FRAME_END) begin
         st = ST_BAD_END;
      end else if (kind != KIND_GYRO && kind != KIND_YAW) begin
         st = ST_OTHER_OK;
      end else if (value_sr[LIMIT_W-1:0] >= INF_BITS) begin
         st = ST_NAN;
      end else if (kind == KIND_GYRO) begin
         if (value_sr[LIMIT_W-1:0] > gyro_limit) begin
            st = ST_RANGE;
         end else begin
            gyro_bits    = value_sr;
            gyro_seq_cnt = gyro_seq_cnt + 1'b1;
            gyro_seen    = 1'b1;
            st           = ST_GYRO_OK;
         end
      end else if (value_sr[LIMIT_W-1:0] > yaw_limit) begin
         st = ST_RANGE;
      end else begin
         yaw_bits    = value_sr;
         yaw_seq_cnt = yaw_seq_cnt + 1'b1;
         yaw_seen    = 1'b1;
         st          = ST_YAW_OK;
      end
      rehunt(b);
      log_result(st);
   endtask

   // compare one result transaction with the oldest expectation
   task automatic check_result();
      rsp_item_type want;
      if (expected_q.size() == 0) begin
         report_mismatch("result with none expected, status", 32'(rsp.frame_status),
                         32'd0);
         return;
      end
      want = expected_q.pop_front();
      compared++;
      check_field("frame_status", 32'(rsp.frame_status), 32'(want.frame_status));
      check_field("gyro_value_bits", rsp.gyro_value_bits, want.gyro_value_bits);
      check_field("gyro_count", rsp.gyro_count, want.gyro_count);
      check_field("gyro_ok", 32'(rsp.gyro_ok), 32'(want.gyro_ok));
      check_field("yaw_value_bits", rsp.yaw_value_bits, want.yaw_value_bits);
      check_field("yaw_count", rsp.yaw_count, want.yaw_count);
      check_field("yaw_ok", 32'(rsp.yaw_ok), 32'(want.yaw_ok));
      check_field("good_frames", rsp.good_frames, want.good_frames);
      check_field("bad_frames", rsp.bad_frames, want.bad_frames);
   endtask

   // results first: a byte's result can only appear from the next cycle on
   always @(posedge clock) begin
      if (reset) begin
         gyro_limit   = GYRO_LIMIT_RST;
         yaw_limit    = YAW_LIMIT_RST;
         position     = POS_HUNT;
         frame_len    = '0;
         kind         = '0;
         value_sr     = '0;
         gyro_bits    = '0;
         gyro_seq_cnt = '0;
         gyro_seen    = 1'b0;
         yaw_bits     = '0;
         yaw_seq_cnt  = '0;
         yaw_seen     = 1'b0;
         good_cnt     = '0;
         bad_cnt      = '0;
         expected_q.delete();
      end else begin
         if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
            check_result();
         end
         if (csr.valid === 1'b1 && csr.ready === 1'b1) begin
            case (csr.index)
               CSR_GYRO_LIMIT: gyro_limit = csr.data[LIMIT_W-1:0];
               CSR_YAW_LIMIT:  yaw_limit  = csr.data[LIMIT_W-1:0];
               default: ;
            endcase
         end
         if (req.valid === 1'b1 && req.ready === 1'b1) begin
            consume_byte(req.rx_byte);
         end
      end
      errors  <= mismatches;
      pending <= expected_q.size();
      checked <= compared;
   end

endmodule

// ----- tb/sv/imu_serial_frame_parser_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_serial_frame_parser_test: top level test of the IMU frame parser
// Sends directed frames (every type, values on and past the limits, NaN and
// infinity, bad types, bad terminators, broken headers), then random frames,
// noise and cut-off frames under several limit settings, with random idling
// on both channels and one long result hold-off. The checker beside the
// block predicts and compares; this module makes stimulus and gives verdict.
// ----------------------------------------------------------------------------
module imu_serial_frame_parser_test;
   import imu_sfp_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned RESET_CYCLES  = 10;
   localparam int unsigned HOLD_CYCLES   = 80;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned RANDOM_BYTES  = 450;
   localparam int unsigned PHASES        = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // value bit patterns
   localparam logic [31:0] GYRO_TYPICAL = 32'h42C80000; // 100.0
   localparam logic [31:0] YAW_TYPICAL  = 32'h42B40000; // 90.0
   localparam logic [31:0] NEG_ZERO     = 32'h80000000;
   localparam logic [31:0] POS_INF      = 32'h7F800000;
   localparam logic [31:0] NEG_INF      = 32'hFF800000;
   localparam logic [31:0] QUIET_NAN    = 32'h7FC00001;
   localparam logic [31:0] ALL_ONES     = 32'hFFFFFFFF;
   localparam logic [31:0] LIMIT_MAX    = 32'h7F7FFFFF; // largest finite

   // type bytes that no frame uses, and a byte that breaks a header
   localparam logic [7:0] KIND_ZERO  = 8'h00;
   localparam logic [7:0] KIND_PAST  = 8'h05;
   localparam logic [7:0] KIND_ONES  = 8'hFF;
   localparam logic [7:0] STRAY_BYTE = 8'h12;

   logic clock = 1'b0;
   logic reset;

   imu_sfp_req_if req ();
   imu_sfp_rsp_if rsp ();
   imu_sfp_csr_if csr ();

   int errors;
   int pending;
   int checked;

   logic [7:0]         frame_q[$];
   logic [LIMIT_W-1:0] gyro_lim;
   logic [LIMIT_W-1:0] yaw_lim;
   bit                 idle_on = 1'b1;
   bit                 hold_off = 1'b0;
   int unsigned        bytes_sent = 0;
   int unsigned        csr_writes = 0;
   int unsigned        holds = 0;
   int unsigned        cycle_count = 0;

   imu_serial_frame_parser i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr)
   );

   imu_serial_frame_parser_checker i_checker (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .rsp     (rsp),
      .csr     (csr),
      .errors  (errors),
      .pending (pending),
      .checked (checked)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("CHECK FAILED");
      $finish;
   end

   // result side: random stalls, one long hold-off on request
   initial begin : rsp_drain
      rsp.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off = 1'b0;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end else begin
            rsp.ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // one byte transaction, entered and left at a falling edge
   task automatic send_byte(input logic [7:0] b);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req.valid   <= 1'b1;
      req.rx_byte <= b;
      do @(posedge clock); while (req.ready !== 1'b1);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_queue();
      foreach (frame_q[i]) send_byte(frame_q[i]);
   endtask

   // header, id, type, body with the value at bytes 12..15, end byte;
   // a type that gives no frame length ends the frame at the type byte
   task automatic build_frame(input logic [7:0] kind_byte, input logic [31:0] value,
                              input logic [7:0] end_byte);
      int unsigned len;
      frame_q = {};
      frame_q.push_back(HDR_FIRST);
      frame_q.push_back(HDR_SECOND);
      frame_q.push_back(8'($urandom));
      frame_q.push_back(kind_byte);
      if (kind_byte >= KIND_FIRST && kind_byte <= KIND_YAW) begin
         len = LEN_STD;
      end else if (kind_byte == KIND_QUAT) begin
         len = LEN_QUAT;
      end else begin
         return;
      end
      for (int unsigned p = POS_BODY; p < len - 1; p++) begin
         if (p >= VAL_OFFSET && p <= VAL_LAST) begin
            frame_q.push_back(value[8*(p-VAL_OFFSET) +: 8]);
         end else begin
            frame_q.push_back(8'($urandom));
         end
      end
      frame_q.push_back(end_byte);
   endtask

   task automatic send_frame(input logic [7:0] kind_byte, input logic [31:0] value,
                             input logic [7:0] end_byte);
      build_frame(kind_byte, value, end_byte);
      send_queue();
   endtask

   // value around a limit: inside, on, just past, inf, NaN, anything
   function automatic logic [31:0] pick_value(input logic [LIMIT_W-1:0] lim);
      logic          sgn;
      logic [30:0]   mag;
      sgn = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 7))
         0, 1: mag = 31'($urandom_range(32'(lim), 0));
         2:    mag = lim;
         3:    mag = (lim == '1) ? lim : lim + 1'b1;
         4:    mag = INF_BITS;
         5:    mag = INF_BITS | 31'($urandom_range(32'h007FFFFF, 1));
         6:    mag = 31'($urandom_range(255, 0));
         default: mag = 31'($urandom);
      endcase
      return {sgn, mag};
   endfunction

   // mostly well-formed frames, some noise, bad types and cut-off frames
   task automatic random_phase(input int unsigned target);
      int unsigned done;
      int unsigned cut;
      logic [7:0]  kind_byte;
      logic [31:0] value;
      logic [7:0]  end_byte;
      done = 0;
      while (done < target) begin
         case ($urandom_range(0, 9))
            7: begin
               frame_q = {};
               repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom));
               send_queue();
            end
            8: begin
               build_frame(8'($urandom), pick_value(gyro_lim), FRAME_END);
               done += frame_q.size();
               send_queue();
            end
            9: begin
               build_frame(KIND_GYRO, pick_value(gyro_lim), FRAME_END);
               cut = $urandom_range(frame_q.size() - 1, 4);
               frame_q = frame_q[0:cut-1];
               done += frame_q.size();
               send_queue();
            end
            default: begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3: kind_byte = KIND_GYRO;
                  4, 5, 6, 7: kind_byte = KIND_YAW;
                  8:          kind_byte = KIND_FIRST;
                  default:    kind_byte = KIND_QUAT;
               endcase
               value    = pick_value((kind_byte == KIND_YAW) ? yaw_lim : gyro_lim);
               end_byte = ($urandom_range(0, 9) == 0) ? 8'($urandom) : FRAME_END;
               build_frame(kind_byte, value, end_byte);
               done += frame_q.size();
               send_queue();
            end
         endcase
      end
   endtask

   // stop sending and let every expected result drain
   task automatic wait_idle();
      req.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= value;
      do @(posedge clock); while (csr.ready !== 1'b1);
      @(negedge clock);
      csr.valid <= 1'b0;
      @(negedge clock);
      if (idx == CSR_GYRO_LIMIT) begin
         gyro_lim = value[LIMIT_W-1:0];
      end else if (idx == CSR_YAW_LIMIT) begin
         yaw_lim = value[LIMIT_W-1:0];
      end
      csr_writes++;
   endtask

   initial begin : stimulus
      reset       = 1'b1;
      req.valid   = 1'b0;
      req.rx_byte = '0;
      csr.valid   = 1'b0;
      csr.index   = CSR_GYRO_LIMIT;
      csr.data    = '0;
      gyro_lim    = GYRO_LIMIT_RST;
      yaw_lim     = YAW_LIMIT_RST;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // every frame type, good
      send_frame(KIND_GYRO, GYRO_TYPICAL, FRAME_END);
      send_frame(KIND_YAW, YAW_TYPICAL, FRAME_END);
      send_frame(KIND_FIRST, $urandom, FRAME_END);
      send_frame(KIND_QUAT, $urandom, FRAME_END);
      // values on and just past the reset limits, signs, negative zero
      send_frame(KIND_GYRO, {1'b0, GYRO_LIMIT_RST}, FRAME_END);
      send_frame(KIND_GYRO, {1'b1, GYRO_LIMIT_RST}, FRAME_END);
      send_frame(KIND_GYRO, {1'b0, GYRO_LIMIT_RST + 1'b1}, FRAME_END);
      send_frame(KIND_YAW, {1'b1, YAW_LIMIT_RST + 1'b1}, FRAME_END);
      send_frame(KIND_YAW, NEG_ZERO, FRAME_END);
      // NaN and infinity
      send_frame(KIND_GYRO, POS_INF, FRAME_END);
      send_frame(KIND_YAW, NEG_INF, FRAME_END);
      send_frame(KIND_GYRO, QUIET_NAN, FRAME_END);
      send_frame(KIND_YAW, ALL_ONES, FRAME_END);
      // wrong terminator
      send_frame(KIND_GYRO, GYRO_TYPICAL, ~FRAME_END);
      send_frame(KIND_QUAT, $urandom, HDR_SECOND);
      // bad types
      send_frame(KIND_ZERO, '0, FRAME_END);
      send_frame(KIND_PAST, '0, FRAME_END);
      send_frame(KIND_ONES, '0, FRAME_END);
      // bad type 0x55 doubles as the next frame's first header byte
      send_frame(HDR_FIRST, '0, FRAME_END);
      build_frame(KIND_YAW, YAW_TYPICAL, FRAME_END);
      void'(frame_q.pop_front());
      send_queue();
      // broken header, then 0x55 0x55 0xAA
      frame_q = {HDR_FIRST, STRAY_BYTE, HDR_FIRST};
      send_queue();
      send_frame(KIND_GYRO, pick_value(gyro_lim), FRAME_END);
      // end byte 0x55 starts the next header
      send_frame(KIND_GYRO, GYRO_TYPICAL, HDR_FIRST);
      build_frame(KIND_GYRO, pick_value(gyro_lim), FRAME_END);
      void'(frame_q.pop_front());
      send_queue();
      wait_idle();

      // long result hold-off while short bad-type frames keep coming
      hold_off = 1'b1;
      holds++;
      repeat (12) begin
         send_frame(8'($urandom_range(255, 5)), '0, FRAME_END);
      end
      random_phase(RANDOM_BYTES / PHASES);
      wait_idle();

      // tightest limits: only zero magnitude passes
      write_csr(CSR_GYRO_LIMIT, '0);
      write_csr(CSR_YAW_LIMIT, '0);
      send_frame(KIND_GYRO, NEG_ZERO, FRAME_END);
      random_phase(RANDOM_BYTES / PHASES);
      wait_idle();

      // widest finite limits
      write_csr(CSR_GYRO_LIMIT, LIMIT_MAX);
      write_csr(CSR_YAW_LIMIT, LIMIT_MAX);
      send_frame(KIND_YAW, LIMIT_MAX, FRAME_END);
      random_phase(RANDOM_BYTES / PHASES);
      wait_idle();

      // gyro limit above infinity: NaN/inf still rejected, all finite pass;
      // an unused register index must change nothing
      write_csr(CSR_GYRO_LIMIT, ALL_ONES);
      write_csr(CSR_YAW_LIMIT, $urandom_range(LIMIT_MAX, 0));
      write_csr(CSR_UNUSED, $urandom);
      send_frame(KIND_GYRO, {1'b1, LIMIT_MAX[30:0]}, FRAME_END);
      send_frame(KIND_GYRO, POS_INF, FRAME_END);
      random_phase(RANDOM_BYTES / PHASES);
      wait_idle();

      // random limits, no idling on either side
      idle_on = 1'b0;
      write_csr(CSR_GYRO_LIMIT, $urandom_range(LIMIT_MAX, 0));
      write_csr(CSR_YAW_LIMIT, $urandom_range(LIMIT_MAX, 0));
      random_phase(RANDOM_BYTES / PHASES);
      wait_idle();

      $display("sent %0d bytes over %0d limit writes and %0d long result hold-off",
               bytes_sent, csr_writes, holds);
      $display("compared %0d result transactions, %0d mismatches", checked, errors);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/imu_sfp_pkg.sv
design/imu_sfp_if.sv
design/imu_serial_frame_parser.sv
tb/sv/imu_serial_frame_parser_checker.sv
tb/sv/imu_serial_frame_parser_test.sv
